/* rtl/stepper_target_positioner_macros.svh */
// ------------------------------------------------------------------------
// Stepper target positioner assertion macros
// Shared concurrent assertion forms for the positioner RTL.
// ------------------------------------------------------------------------
`ifndef STEPPER_TARGET_POSITIONER_MACROS_SVH
`define STEPPER_TARGET_POSITIONER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define STP_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("stepper positioner check failed");

// Next-cycle implication, disabled during reset.
`define STP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("stepper positioner check failed");

`endif

/* rtl/stp_pkg.sv */
// ------------------------------------------------------------------------
// Stepper positioner package
// Shared types, codes, register defaults and a helper function.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package stp_pkg;

   localparam int POS_W   = 16;
   localparam int COUNT_W = 10;
   localparam int SPEED_W = 4;
   localparam int HALF_W  = 10;
   localparam int OFF_W   = 12;
   localparam int CSR_IDX_W = 3;

   localparam int STALL_TICKS_DEFAULT   = 500;
   localparam int REISSUE_TICKS_DEFAULT = 20;

   // Reissue counter load value that forces a step on a speed change.
   localparam logic [COUNT_W-1:0] REISSUE_RELOAD = COUNT_W'(1000);
   localparam logic [POS_W-1:0]   POS_MAX        = '1;

   // Item opcodes.
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Approach sides.
   localparam logic [1:0] SIDE_EITHER = 2'd0;
   localparam logic [1:0] SIDE_BELOW  = 2'd1;
   localparam logic [1:0] SIDE_ABOVE  = 2'd2;

   // Speed band selectors into the packed speed code register.
   localparam logic [1:0] BAND_FAST   = 2'd0;
   localparam logic [1:0] BAND_MEDIUM = 2'd1;
   localparam logic [1:0] BAND_SLOW   = 2'd2;
   localparam logic [1:0] BAND_CRAWL  = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_DISTANCE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLOSE_DISTANCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_DISTANCE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_CODES    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_STEP      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_APPROACH_OFF   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_LIMIT    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_LIMIT    = 3'd7;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_PRE   = 2'd1,
      PHASE_FINAL = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_IDLE    = 2'd0,
      STATUS_MOVING  = 2'd1,
      STATUS_ARRIVED = 2'd2,
      STATUS_STALLED = 2'd3
   } status_type;

   typedef struct packed {
      logic [POS_W-1:0]  far_distance;
      logic [POS_W-1:0]  close_distance;
      logic [POS_W-1:0]  near_distance;
      logic [POS_W-1:0]  speed_codes;
      logic [HALF_W-1:0] half_step;
      logic [OFF_W-1:0]  approach_offset;
      logic [POS_W-1:0]  lower_limit;
      logic [POS_W-1:0]  upper_limit;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      far_distance:    16'd200,
      close_distance:  16'd100,
      near_distance:   16'd50,
      speed_codes:     16'd17440,
      half_step:       10'd4,
      approach_offset: 12'd100,
      lower_limit:     16'd0,
      upper_limit:     16'd65535
   };

   // Direction and clamped target of one phase.
   typedef struct packed {
      logic             down;
      logic [POS_W-1:0] target;
   } plan_type;

   // Per-phase progress tracking state.
   typedef struct packed {
      logic [POS_W-1:0]   best;
      logic [COUNT_W-1:0] no_progress;
      logic [COUNT_W-1:0] reissue;
      logic [SPEED_W-1:0] speed;
   } track_type;

   // Tick evaluation results handed to the control logic.
   typedef struct packed {
      logic               go;
      logic               stalled;
      logic               step;
      logic [SPEED_W-1:0] speed;
   } tick_type;

   // Selects one speed code nibble from the packed register.
   function automatic logic [SPEED_W-1:0] code_of(input logic [POS_W-1:0] codes,
                                                  input logic [1:0] band);
      logic [SPEED_W-1:0] code;
      case (band)
         BAND_FAST:   code = codes[3:0];
         BAND_MEDIUM: code = codes[7:4];
         BAND_SLOW:   code = codes[11:8];
         BAND_CRAWL:  code = codes[15:12];
         default:     code = codes[3:0];
      endcase
      return code;
   endfunction

endpackage

/* rtl/stp_csr.sv */
// ------------------------------------------------------------------------
// Stepper positioner configuration registers
// Holds the eight configuration registers written through the CSR port.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [stp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stp_pkg::POS_W-1:0]       csr_data,
   output stp_pkg::cfg_type                cfg
);

   stp_pkg::cfg_type cfg_ff;
   stp_pkg::cfg_type cfg_in;

   // The register file never back-pressures a write.
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the register index of a write transaction.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            stp_pkg::CSR_FAR_DISTANCE:   cfg_in.far_distance    = csr_data;
            stp_pkg::CSR_CLOSE_DISTANCE: cfg_in.close_distance  = csr_data;
            stp_pkg::CSR_NEAR_DISTANCE:  cfg_in.near_distance   = csr_data;
            stp_pkg::CSR_SPEED_CODES:    cfg_in.speed_codes     = csr_data;
            stp_pkg::CSR_HALF_STEP:
               cfg_in.half_step = csr_data[stp_pkg::HALF_W-1:0];
            stp_pkg::CSR_APPROACH_OFF:
               cfg_in.approach_offset = csr_data[stp_pkg::OFF_W-1:0];
            stp_pkg::CSR_LOWER_LIMIT:    cfg_in.lower_limit     = csr_data;
            stp_pkg::CSR_UPPER_LIMIT:    cfg_in.upper_limit     = csr_data;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= stp_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/stp_target.sv */
// ------------------------------------------------------------------------
// Stepper positioner phase planner
// Decides arrival on start and computes clamped pre-move and final targets.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_target (
   input  logic [stp_pkg::POS_W-1:0] goal,
   input  logic [stp_pkg::POS_W-1:0] position,
   input  logic [1:0]                approach_side,
   input  stp_pkg::cfg_type          cfg,
   output logic                      arrive_now,
   output logic                      start_pre,
   output stp_pkg::plan_type         start_plan,
   output stp_pkg::plan_type         final_plan
);

   localparam int W = stp_pkg::POS_W;

   logic [W-1:0] distance;
   logic [W:0]   tolerance;
   logic [W:0]   offset_ext;
   logic [W:0]   half_ext;
   logic [W:0]   goal_plus_off;
   logic [W:0]   goal_minus_off;
   logic [W:0]   goal_plus_half;
   logic [W:0]   goal_minus_half;
   logic [W:0]   position_plus_off;
   logic [W-1:0] below_target;
   logic [W-1:0] above_target;
   logic [W-1:0] final_target;
   logic         final_down;
   logic         pre_below;
   logic         pre_above;

   // Limits the saturated target to the configured travel range.
   function automatic logic [W-1:0] clamp_limits(input logic [W-1:0] value,
                                                 input logic [W-1:0] lower,
                                                 input logic [W-1:0] upper);
      logic [W-1:0] result;
      if (value < lower) begin
         result = lower;
      end else if (value > upper) begin
         result = upper;
      end else begin
         result = value;
      end
      return result;
   endfunction

   // Saturating sums, one bit wider to catch the carry or borrow.
   assign offset_ext        = (W+1)'(cfg.approach_offset);
   assign half_ext          = (W+1)'(cfg.half_step);
   assign goal_plus_off     = {1'b0, goal} + offset_ext;
   assign goal_minus_off    = {1'b0, goal} - offset_ext;
   assign goal_plus_half    = {1'b0, goal} + half_ext;
   assign goal_minus_half   = {1'b0, goal} - half_ext;
   assign position_plus_off = {1'b0, position} + offset_ext;

   // Arrival test: distance strictly below twice the half-step.
   assign distance   = (position > goal) ? (position - goal) : (goal - position);
   assign tolerance  = (W+1)'({cfg.half_step, 1'b0});
   assign arrive_now = {1'b0, distance} < tolerance;

   assign below_target = goal_minus_off[W] ? '0 : goal_minus_off[W-1:0];
   assign above_target = goal_plus_off[W] ? stp_pkg::POS_MAX : goal_plus_off[W-1:0];

   // The final approach stops a half-step short on the side the position is on.
   always_comb begin
      final_down = position > goal;
      if (final_down) begin
         final_target = goal_plus_half[W] ? stp_pkg::POS_MAX : goal_plus_half[W-1:0];
      end else begin
         final_target = goal_minus_half[W] ? '0 : goal_minus_half[W-1:0];
      end
      final_plan.down   = final_down;
      final_plan.target = clamp_limits(final_target, cfg.lower_limit, cfg.upper_limit);
   end

   // A pre-move is needed when the position is not yet past the overshoot point.
   assign pre_below = (approach_side == stp_pkg::SIDE_BELOW) &&
                      (position_plus_off > {1'b0, goal});
   assign pre_above = (approach_side == stp_pkg::SIDE_ABOVE) &&
                      ({1'b0, position} < goal_plus_off);
   assign start_pre = pre_below || pre_above;

   always_comb begin
      if (pre_below) begin
         start_plan.down   = 1'b1;
         start_plan.target = clamp_limits(below_target, cfg.lower_limit, cfg.upper_limit);
      end else if (pre_above) begin
         start_plan.down   = 1'b0;
         start_plan.target = clamp_limits(above_target, cfg.lower_limit, cfg.upper_limit);
      end else begin
         start_plan = final_plan;
      end
   end

endmodule

/* rtl/stp_tracker.sv */
// ------------------------------------------------------------------------
// Stepper positioner tick tracker
// Picks the speed band, follows progress and paces step commands.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module stp_tracker #(
   parameter int STALL_TICKS   = stp_pkg::STALL_TICKS_DEFAULT,
   parameter int REISSUE_TICKS = stp_pkg::REISSUE_TICKS_DEFAULT
) (
   input  logic                      phase_down,
   input  logic [stp_pkg::POS_W-1:0] phase_target,
   input  stp_pkg::track_type        track,
   input  logic [stp_pkg::POS_W-1:0] position,
   input  stp_pkg::cfg_type          cfg,
   output stp_pkg::tick_type         tick,
   output stp_pkg::track_type        track_next
);

   localparam int CW = stp_pkg::COUNT_W;
   localparam logic [CW-1:0] STALL_LIMIT   = CW'(STALL_TICKS);
   localparam logic [CW-1:0] REISSUE_LIMIT = CW'(REISSUE_TICKS);

   logic [stp_pkg::POS_W-1:0]   distance;
   logic [1:0]                  band;
   logic [stp_pkg::SPEED_W-1:0] new_speed;
   logic                        better;
   logic [CW-1:0]               no_progress_eff;
   logic [CW-1:0]               reissue_eff;
   logic                        step_fire;

   // The phase runs while the position has not reached the target.
   assign tick.go   = phase_down ? (position > phase_target) : (position < phase_target);
   assign distance  = phase_down ? (position - phase_target) : (phase_target - position);

   // Speed band: up moves never use the crawl band.
   always_comb begin
      if (distance > cfg.far_distance) begin
         band = stp_pkg::BAND_FAST;
      end else if (distance > cfg.close_distance) begin
         band = stp_pkg::BAND_MEDIUM;
      end else if (!phase_down || distance > cfg.near_distance) begin
         band = stp_pkg::BAND_SLOW;
      end else begin
         band = stp_pkg::BAND_CRAWL;
      end
   end

   assign new_speed = stp_pkg::code_of(cfg.speed_codes, band);
   assign better    = phase_down ? (position < track.best) : (position > track.best);

   // A speed change forces an immediate reissue; a new best restarts stall timing.
   assign reissue_eff     = (new_speed != track.speed) ? stp_pkg::REISSUE_RELOAD
                                                       : track.reissue;
   assign no_progress_eff = better ? '0 : track.no_progress;
   assign tick.stalled    = tick.go && (no_progress_eff > STALL_LIMIT);
   assign tick.speed      = new_speed;
   assign tick.step       = step_fire;

   // Counter updates for a running phase.
   always_comb begin
      track_next = track;
      step_fire  = 1'b0;
      if (tick.go) begin
         track_next.speed       = new_speed;
         track_next.best        = better ? position : track.best;
         track_next.no_progress = no_progress_eff;
         track_next.reissue     = reissue_eff;
         if (!tick.stalled) begin
            track_next.no_progress = no_progress_eff + 1'b1;
            if (reissue_eff > REISSUE_LIMIT) begin
               track_next.reissue = '0;
               step_fire          = 1'b1;
            end else begin
               track_next.reissue = reissue_eff + 1'b1;
            end
         end
      end
   end

endmodule

/* rtl/stepper_target_positioner.sv */
// ------------------------------------------------------------------------
// Stepper target positioner
// Two-phase stepper move controller with one-sided backlash take-up.
// ------------------------------------------------------------------------
// The block takes one transaction per clock cycle while req_stall is low:
// a start or a position tick is evaluated in the cycle it is accepted,
// the phase state updates at that edge, and its single result transaction
// appears on the rsp_ side in the next cycle from the result register.
// req_stall rises only while that result register holds an untaken
// result and rsp_stall is high, so with an open output the sustained
// rate is one item per cycle. Configuration writes are accepted every
// cycle (csr_ready is always high) and should be made while no move runs.
`timescale 1ns / 1ps

`include "stepper_target_positioner_macros.svh"

module stepper_target_positioner #(
   parameter int STALL_TICKS   = stp_pkg::STALL_TICKS_DEFAULT,
   parameter int REISSUE_TICKS = stp_pkg::REISSUE_TICKS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // Item input channel.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [stp_pkg::POS_W-1:0]         req_goal,
   input  logic [1:0]                        req_approach_side,
   input  logic [stp_pkg::POS_W-1:0]         req_sensed_position,
   // Result channel.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_step_now,
   output logic [stp_pkg::SPEED_W-1:0]       rsp_step_speed,
   output logic                              rsp_move_down,
   output logic                              rsp_stop_now,
   output logic [1:0]                        rsp_move_status,
   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [stp_pkg::POS_W-1:0]         csr_data
);

   localparam logic [stp_pkg::COUNT_W-1:0] NO_PROGRESS_MAX =
      stp_pkg::COUNT_W'(STALL_TICKS + 1);

   stp_pkg::cfg_type   cfg;
   stp_pkg::plan_type  start_plan;
   stp_pkg::plan_type  final_plan;
   stp_pkg::tick_type  tick;
   stp_pkg::track_type track_next;
   stp_pkg::plan_type  begin_plan;

   // Move state.
   stp_pkg::phase_type          phase_ff, phase_in;
   logic                        phase_down_ff, phase_down_in;
   logic [stp_pkg::POS_W-1:0]   phase_target_ff, phase_target_in;
   logic [stp_pkg::POS_W-1:0]   command_target_ff, command_target_in;
   stp_pkg::track_type          track_ff, track_in;
   logic                        stall_seen_ff, stall_seen_in;

   // Result register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        step_now_ff, step_now_in;
   logic [stp_pkg::SPEED_W-1:0] step_speed_ff, step_speed_in;
   logic                        move_down_ff, move_down_in;
   logic                        stop_now_ff, stop_now_in;
   stp_pkg::status_type         status_ff, status_in;

   logic                        accept;
   logic                        begin_phase;
   stp_pkg::phase_type          begin_which;
   logic                        arrive_now;
   logic                        start_pre;
   logic [stp_pkg::POS_W-1:0]   goal_sel;
   logic                        stall_seen_new;

   stp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The final approach aims at the new goal on a start and the stored one on a tick.
   assign goal_sel = (req_opcode == stp_pkg::OP_START) ? req_goal : command_target_ff;

   stp_target u_target (
      .goal          (goal_sel),
      .position      (req_sensed_position),
      .approach_side (req_approach_side),
      .cfg           (cfg),
      .arrive_now    (arrive_now),
      .start_pre     (start_pre),
      .start_plan    (start_plan),
      .final_plan    (final_plan)
   );

   stp_tracker #(
      .STALL_TICKS   (STALL_TICKS),
      .REISSUE_TICKS (REISSUE_TICKS)
   ) u_tracker (
      .phase_down   (phase_down_ff),
      .phase_target (phase_target_ff),
      .track        (track_ff),
      .position     (req_sensed_position),
      .cfg          (cfg),
      .tick         (tick),
      .track_next   (track_next)
   );

   // Input is held back only while an untaken result blocks the register.
   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;

   // Next move state and result for an accepted transaction.
   always_comb begin
      phase_in          = phase_ff;
      phase_down_in     = phase_down_ff;
      phase_target_in   = phase_target_ff;
      command_target_in = command_target_ff;
      track_in          = track_ff;
      stall_seen_in     = stall_seen_ff;
      step_now_in       = 1'b0;
      step_speed_in     = '0;
      move_down_in      = 1'b0;
      stop_now_in       = 1'b0;
      status_in         = stp_pkg::STATUS_IDLE;
      begin_phase       = 1'b0;
      begin_which       = stp_pkg::PHASE_FINAL;
      begin_plan        = final_plan;
      stall_seen_new    = stall_seen_ff;

      if (accept) begin
         if (req_opcode == stp_pkg::OP_START) begin
            // Start: a running move is dropped.
            stall_seen_in     = 1'b0;
            command_target_in = req_goal;
            if (arrive_now) begin
               phase_in  = stp_pkg::PHASE_IDLE;
               status_in = stp_pkg::STATUS_ARRIVED;
            end else begin
               begin_phase  = 1'b1;
               begin_which  = start_pre ? stp_pkg::PHASE_PRE : stp_pkg::PHASE_FINAL;
               begin_plan   = start_plan;
               status_in    = stp_pkg::STATUS_MOVING;
               move_down_in = start_plan.down;
            end
         end else if (phase_ff != stp_pkg::PHASE_IDLE) begin
            track_in = track_next;
            if (!tick.go || tick.stalled) begin
               // Phase end: stop, then either the final approach or the end of the move (arrived or stalled).
               stop_now_in    = 1'b1;
               move_down_in   = phase_down_ff;
               stall_seen_new = stall_seen_ff || tick.stalled;
               stall_seen_in  = stall_seen_new;
               if (phase_ff == stp_pkg::PHASE_PRE) begin
                  begin_phase = 1'b1;
                  status_in   = stp_pkg::STATUS_MOVING;
               end else begin
                  phase_in  = stp_pkg::PHASE_IDLE;
                  status_in = stall_seen_new ? stp_pkg::STATUS_STALLED
                                             : stp_pkg::STATUS_ARRIVED;
               end
            end else begin
               status_in     = stp_pkg::STATUS_MOVING;
               move_down_in  = phase_down_ff;
               step_now_in   = tick.step;
               step_speed_in = tick.step ? tick.speed : '0;
            end
         end
      end

      // Phase start loads a fresh target and tracking state.
      if (begin_phase) begin
         phase_in        = begin_which;
         phase_down_in   = begin_plan.down;
         phase_target_in = begin_plan.target;
         track_in.best   = begin_plan.down ? stp_pkg::POS_MAX : '0;
         track_in.no_progress = '0;
         track_in.reissue     = '0;
         track_in.speed       = stp_pkg::code_of(cfg.speed_codes, stp_pkg::BAND_FAST);
      end
   end

   // The result register holds until the transaction is taken.
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= stp_pkg::PHASE_IDLE;
         phase_down_ff     <= 1'b0;
         phase_target_ff   <= '0;
         command_target_ff <= '0;
         track_ff          <= '0;
         stall_seen_ff     <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         phase_down_ff     <= phase_down_in;
         phase_target_ff   <= phase_target_in;
         command_target_ff <= command_target_in;
         track_ff          <= track_in;
         stall_seen_ff     <= stall_seen_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Result payload loads only on an accepted transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         step_now_ff   <= step_now_in;
         step_speed_ff <= step_speed_in;
         move_down_ff  <= move_down_in;
         stop_now_ff   <= stop_now_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_step_now    = step_now_ff;
   assign rsp_step_speed  = step_speed_ff;
   assign rsp_move_down   = move_down_ff;
   assign rsp_stop_now    = stop_now_ff;
   assign rsp_move_status = status_ff;

   // A step command is only issued while the move continues.
   `STP_ASSERT_SAME(a_step_while_moving, clock, reset, rsp_valid && rsp_step_now, rsp_move_status == stp_pkg::STATUS_MOVING)
   // A stop always belongs to an active move.
   `STP_ASSERT_SAME(a_stop_not_idle, clock, reset, rsp_valid && rsp_stop_now, rsp_move_status != stp_pkg::STATUS_IDLE)
   // A tick with no move running yields an idle result.
   `STP_ASSERT_NEXT(a_idle_tick, clock, reset, accept && req_opcode == stp_pkg::OP_TICK && phase_ff == stp_pkg::PHASE_IDLE, rsp_valid && rsp_move_status == stp_pkg::STATUS_IDLE && !rsp_stop_now)
   // The stall counter never runs past its limit.
   `STP_ASSERT_SAME(a_no_progress_bound, clock, reset, 1'b1, track_ff.no_progress <= NO_PROGRESS_MAX)

endmodule
